[hw/rtl/erm_pkg.sv]
package erm_pkg;

    localparam int unsigned WIDTH_W = 16;
    localparam int unsigned DUR_W   = 14;
    localparam int unsigned DIST_W  = 8;
    localparam int unsigned PROD_W  = 19;
    localparam int unsigned QUOT_W  = 10;
    localparam int unsigned REM_W   = 20;
    localparam int unsigned MUL_W   = 30;
    localparam int unsigned SUM_W   = 11;
    localparam int unsigned TRIM_W  = 10;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned DATA_W  = 32;

    localparam logic [DUR_W-1:0]   MIN_DUR_RESET = 14'd116;
    localparam logic [DUR_W-1:0]   MAX_DUR_RESET = 14'd11764;
    localparam logic [CNT_W-1:0]   GROUP_LAST    = 3'd5;
    localparam logic [10:0]        RECIP         = 11'd1048;
    localparam int unsigned        RECIP_SHIFT   = 20;
    localparam logic [QUOT_W-1:0]  CM_DEN        = 10'd1000;
    localparam logic [DIST_W-1:0]  DIST_SAT      = 8'd255;
    localparam logic [DIST_W-1:0]  MIN_RESET     = 8'd255;

    localparam logic [ADDR_W-1:0]  ADDR_MIN_DUR  = 3'd0;
    localparam logic [ADDR_W-1:0]  ADDR_MAX_DUR  = 3'd4;

    typedef struct packed {
        logic [DIST_W-1:0] distance_cm;
        logic [DIST_W-1:0] smoothed_cm;
        logic              smoothed_ready;
    } t_result;

endpackage

[hw/rtl/erm_queue.sv]
module erm_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (rd_en) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hw/rtl/erm_front.sv]
module erm_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [erm_pkg::WIDTH_W-1:0]  i_echo_width,
    input  logic [erm_pkg::DUR_W-1:0]    i_min_dur,
    input  logic [erm_pkg::DUR_W-1:0]    i_max_dur,
    output logic [erm_pkg::PROD_W-1:0]   o_product
);

    logic [erm_pkg::WIDTH_W-1:0] r_prev_width;
    logic [erm_pkg::WIDTH_W-1:0] width_fb;
    logic [erm_pkg::DUR_W-1:0]   width_cl;
    logic                        out_of_range;

    always_comb begin
        width_fb     = (i_echo_width == '0) ? r_prev_width : i_echo_width;
        out_of_range = (width_fb < erm_pkg::WIDTH_W'(i_min_dur))
                    || (width_fb > erm_pkg::WIDTH_W'(i_max_dur));
        width_cl     = out_of_range ? i_max_dur : width_fb[erm_pkg::DUR_W-1:0];
        o_product    = erm_pkg::PROD_W'({width_cl, 4'b0000})
                     + erm_pkg::PROD_W'(width_cl);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_width <= erm_pkg::WIDTH_W'(erm_pkg::MAX_DUR_RESET);
        end else if (i_accept) begin
            r_prev_width <= i_echo_width;
        end
    end

endmodule

[hw/rtl/erm_back.sv]
module erm_back #(
    parameter int unsigned OUT_DEPTH = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_mid_empty,
    input  logic [erm_pkg::PROD_W-1:0]         i_mid_product,
    output logic                               o_mid_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]     i_out_count,
    output logic                               o_out_push,
    output erm_pkg::t_result                   o_result
);

    localparam int unsigned OCNT_W = $clog2(OUT_DEPTH + 1);

    logic                        r_b1_valid;
    logic [erm_pkg::PROD_W-1:0]  r_b1_prod;
    logic [erm_pkg::QUOT_W-1:0]  r_b1_quot;
    logic                        r_b2_valid;
    logic [erm_pkg::DIST_W-1:0]  r_b2_dist;

    logic [erm_pkg::CNT_W-1:0]   r_count;
    logic [erm_pkg::SUM_W-1:0]   r_sum;
    logic [erm_pkg::DIST_W-1:0]  r_max;
    logic [erm_pkg::DIST_W-1:0]  r_min;

    logic [OCNT_W:0]             in_flight;
    logic [erm_pkg::MUL_W-1:0]   recip_prod;
    logic [erm_pkg::REM_W-1:0]   rem;
    logic [erm_pkg::QUOT_W-1:0]  quot;
    logic [erm_pkg::DIST_W-1:0]  n_dist;
    logic [erm_pkg::SUM_W-1:0]   n_sum;
    logic [erm_pkg::DIST_W-1:0]  n_max;
    logic [erm_pkg::DIST_W-1:0]  n_min;
    logic [erm_pkg::SUM_W-1:0]   trim;
    logic                        last;

    always_comb begin
        in_flight = (OCNT_W + 1)'(i_out_count) + (OCNT_W + 1)'(r_b1_valid)
                  + (OCNT_W + 1)'(r_b2_valid);
        o_mid_pop = !i_mid_empty && (in_flight < (OCNT_W + 1)'(OUT_DEPTH));
    end

    always_comb begin
        recip_prod = erm_pkg::MUL_W'(i_mid_product) * erm_pkg::MUL_W'(erm_pkg::RECIP);
    end

    always_comb begin
        rem  = erm_pkg::REM_W'(r_b1_prod)
             - (erm_pkg::REM_W'(r_b1_quot) * erm_pkg::REM_W'(erm_pkg::CM_DEN));
        quot = (rem >= erm_pkg::REM_W'(erm_pkg::CM_DEN)) ? r_b1_quot + 1'b1 : r_b1_quot;
        n_dist = (quot > erm_pkg::QUOT_W'(erm_pkg::DIST_SAT))
               ? erm_pkg::DIST_SAT : quot[erm_pkg::DIST_W-1:0];
    end

    always_comb begin
        n_sum = r_sum + erm_pkg::SUM_W'(r_b2_dist);
        n_max = (r_b2_dist > r_max) ? r_b2_dist : r_max;
        n_min = (r_b2_dist < r_min) ? r_b2_dist : r_min;
        last  = (r_count == erm_pkg::GROUP_LAST);
        trim  = n_sum - erm_pkg::SUM_W'(n_max) - erm_pkg::SUM_W'(n_min);
        o_out_push              = r_b2_valid;
        o_result.distance_cm    = r_b2_dist;
        o_result.smoothed_ready = last;
        o_result.smoothed_cm    = last ? trim[erm_pkg::TRIM_W-1:2] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (o_mid_pop) begin
            r_b1_prod <= i_mid_product;
            r_b1_quot <= recip_prod[erm_pkg::MUL_W-1:erm_pkg::RECIP_SHIFT];
        end
        if (r_b1_valid) begin
            r_b2_dist <= n_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            r_count    <= '0;
            r_sum      <= '0;
            r_max      <= '0;
            r_min      <= erm_pkg::MIN_RESET;
        end else begin
            r_b1_valid <= o_mid_pop;
            r_b2_valid <= r_b1_valid;
            if (r_b2_valid) begin
                if (last) begin
                    r_count <= '0;
                    r_sum   <= '0;
                    r_max   <= '0;
                    r_min   <= erm_pkg::MIN_RESET;
                end else begin
                    r_count <= r_count + 1'b1;
                    r_sum   <= n_sum;
                    r_max   <= n_max;
                    r_min   <= n_min;
                end
            end
        end
    end

endmodule

[hw/rtl/echo_range_trimmed_mean.sv]
// Ultrasonic echo-width to distance converter with six-sample trimmed mean.
// Input queue side: drive i_echo_width with push; a request is taken at a
// clock edge with push high and full low. A width of 0 reuses the last width.
// Result queue side: while empty is low the oldest result sits on
// o_distance_cm, o_smoothed_cm and o_smoothed_ready; pop takes it.
// Every request yields exactly one result, in order. Every sixth result
// carries the trimmed mean and o_smoothed_ready set.
// A request pushed into the input queue passes the reciprocal multiply, the
// remainder fix and the group update before its result can be popped.
// Throughput: one request per cycle sustained while pop keeps the result queue
// drained, limited by the single result write per cycle of the group accumulator.
// When pop stays low the result queue fills, the back end stops draining
// the input queue, and full rises once MID_DEPTH requests are waiting.
// Reset (synchronous, i_rst_n low) empties both queues, clears the group,
// restores min_duration 116 and max_duration 11764 and the last width 11764.
// Configuration: the user must make APB writes at 0x0 (min_duration) and 0x4
// (max_duration) only while no request is in flight; the block does not enforce
// this. OUT_DEPTH of at least 4 keeps the full rate of one request per cycle.
module echo_range_trimmed_mean #(
    parameter int unsigned MID_DEPTH = 4,
    parameter int unsigned OUT_DEPTH = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [erm_pkg::ADDR_W-1:0]  paddr,
    input  logic [erm_pkg::DATA_W-1:0]  pwdata,
    output logic [erm_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        push,
    output logic                        full,
    input  logic [erm_pkg::WIDTH_W-1:0] i_echo_width,
    output logic                        empty,
    input  logic                        pop,
    output logic [erm_pkg::DIST_W-1:0]  o_distance_cm,
    output logic [erm_pkg::DIST_W-1:0]  o_smoothed_cm,
    output logic                        o_smoothed_ready
);

    localparam int unsigned MCNT_W = $clog2(MID_DEPTH + 1);
    localparam int unsigned OCNT_W = $clog2(OUT_DEPTH + 1);
    localparam int unsigned RES_W  = $bits(erm_pkg::t_result);

    logic [erm_pkg::DUR_W-1:0]  r_min_dur;
    logic [erm_pkg::DUR_W-1:0]  r_max_dur;
    logic                       cfg_wr;
    logic                       accept;
    logic [erm_pkg::PROD_W-1:0] front_prod;
    logic [erm_pkg::PROD_W-1:0] mid_prod;
    logic                       mid_empty;
    logic                       mid_pop;
    logic [MCNT_W-1:0]          mid_count;
    logic [OCNT_W-1:0]          out_count;
    logic                       out_push;
    logic                       out_full;
    erm_pkg::t_result           back_res;
    erm_pkg::t_result           head_res;
    logic [RES_W-1:0]           head_bits;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign accept = push && !full;

    always_comb begin
        case (paddr)
            erm_pkg::ADDR_MIN_DUR: prdata = erm_pkg::DATA_W'(r_min_dur);
            erm_pkg::ADDR_MAX_DUR: prdata = erm_pkg::DATA_W'(r_max_dur);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dur <= erm_pkg::MIN_DUR_RESET;
            r_max_dur <= erm_pkg::MAX_DUR_RESET;
        end else if (cfg_wr) begin
            case (paddr)
                erm_pkg::ADDR_MIN_DUR: r_min_dur <= pwdata[erm_pkg::DUR_W-1:0];
                erm_pkg::ADDR_MAX_DUR: r_max_dur <= pwdata[erm_pkg::DUR_W-1:0];
                default: ;
            endcase
        end
    end

    erm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_echo_width (i_echo_width),
        .i_min_dur    (r_min_dur),
        .i_max_dur    (r_max_dur),
        .o_product    (front_prod)
    );

    erm_queue #(
        .WIDTH (erm_pkg::PROD_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_prod),
        .o_full  (full),
        .i_pop   (mid_pop),
        .o_data  (mid_prod),
        .o_empty (mid_empty),
        .o_count (mid_count)
    );

    erm_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mid_empty   (mid_empty || (mid_count == '0)),
        .i_mid_product (mid_prod),
        .o_mid_pop     (mid_pop),
        .i_out_count   (out_count),
        .o_out_push    (out_push),
        .o_result      (back_res)
    );

    erm_queue #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (back_res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (head_bits),
        .o_empty (empty),
        .o_count (out_count)
    );

    always_comb begin
        head_res         = erm_pkg::t_result'(head_bits);
        o_distance_cm    = head_res.distance_cm;
        o_smoothed_cm    = head_res.smoothed_cm;
        o_smoothed_ready = head_res.smoothed_ready && !out_full | head_res.smoothed_ready;
    end

endmodule
